// ----- hw/rtl/dsg_pkg.sv -----
`default_nettype none

package dsg_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_TGT_W = 2'd2,
    CFG_TGT_H = 2'd3
  } cfg_idx_t;

  // Register reset values
  localparam int SRC_W_RST = 800;
  localparam int SRC_H_RST = 640;
  localparam int TGT_W_RST = 160;
  localparam int TGT_H_RST = 120;

  // Luma weights
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  // floor(x*255/31) = 8x + floor(7x/31); floor(n/31) = (n*265)>>13 for n <= 217
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [7:0]  n;
    logic [16:0] q;
    n = 8'(x) * 8'd7;
    q = 17'(n) * 17'd265;
    return 8'({x, 3'b000}) + 8'(q[16:13]);
  endfunction

  // floor(x*255/63) = 4x + floor(x/21); floor(x/21) = (x*49)>>10 for x <= 63
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [11:0] q;
    q = 12'(x) * 12'd49;
    return 8'({x, 2'b00}) + 8'(q[11:10]);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dsg_luma.sv -----
`default_nettype none

module dsg_luma (
  input  wire logic [15:0] pixel,
  output logic      [7:0]  gray
);

  logic [7:0]  r8;
  logic [7:0]  g8;
  logic [7:0]  b8;
  logic [15:0] r_term;
  logic [15:0] g_term;
  logic [15:0] b_term;
  logic [17:0] sum;

  // expand each channel to 8 bits, truncating
  assign r8 = dsg_pkg::expand5(pixel[15:11]);
  assign g8 = dsg_pkg::expand6(pixel[10:5]);
  assign b8 = dsg_pkg::expand5(pixel[4:0]);

  // weighted sum, keep the top byte
  assign r_term = 16'(r8) * 16'(dsg_pkg::LUMA_R);
  assign g_term = 16'(g8) * 16'(dsg_pkg::LUMA_G);
  assign b_term = 16'(b8) * 16'(dsg_pkg::LUMA_B);
  assign sum    = 18'(r_term) + 18'(g_term) + 18'(b_term);
  assign gray   = sum[15:8];

endmodule

`default_nettype wire

// ----- hw/rtl/downsample_rgb565_gray.sv -----
`default_nettype none

// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+-------------------------------
// in_      | input     | in_valid / in_stall | dsg_pkg::in_word_t (pixel, frame_start)
// out_     | output    | out_valid/out_stall | dsg_pkg::out_word_t (gray, row_end, frame_end)
// cfg_     | input     | cfg_we              | cfg_index, cfg_data
//
// One word per clock is sustained unless a selected word meets a stalled result; a selected
// pixel passes the input register, then the result register fed by the selection and luma logic.
// Reset (rst_n low, synchronous) empties both registers, clears positions and sums and
// loads the default sizes. A stalled result holds the pending word in the input register
// only if that word is selected; unselected words keep flowing through.

module downsample_rgb565_gray #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire dsg_pkg::in_word_t                     in_word,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output dsg_pkg::out_word_t                         out_word,
  input  wire logic                                  cfg_we,
  input  wire logic [dsg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [COORD_BITS-1:0]                 cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int SB = 2 * COORD_BITS;

  logic [CB-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [CB-1:0] src_col_r, src_row_r, out_col_r, out_row_r;
  logic [SB-1:0] col_ss_r, col_ts_r, row_ss_r, row_ts_r;
  logic [CB-1:0] src_col_nxt, src_row_nxt, out_col_nxt, out_row_nxt;
  logic [SB-1:0] col_ss_nxt, col_ts_nxt, row_ss_nxt, row_ts_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  dsg_pkg::in_word_t  s1_word_r;
  logic               out_valid_r, out_valid_nxt;
  dsg_pkg::out_word_t out_word_r, out_word_nxt;

  logic [CB-1:0] src_col_e, src_row_e, out_col_e, out_row_e;
  logic [SB-1:0] col_ss_e, col_ts_e, row_ss_e, row_ts_e;
  logic          fs;
  logic          row_hit, col_hit, hit;
  logic          col_last, row_last, last_col, last_row;
  logic          process, load;
  logic [7:0]    gray;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= CB'(dsg_pkg::SRC_W_RST);
      src_h_r <= CB'(dsg_pkg::SRC_H_RST);
      tgt_w_r <= CB'(dsg_pkg::TGT_W_RST);
      tgt_h_r <= CB'(dsg_pkg::TGT_H_RST);
    end else if (cfg_we) begin
      unique case (dsg_pkg::cfg_idx_t'(cfg_index))
        dsg_pkg::CFG_SRC_W: src_w_r <= cfg_data;
        dsg_pkg::CFG_SRC_H: src_h_r <= cfg_data;
        dsg_pkg::CFG_TGT_W: tgt_w_r <= cfg_data;
        dsg_pkg::CFG_TGT_H: tgt_h_r <= cfg_data;
      endcase
    end
  end

  // apply frame start before the selection test
  assign fs        = s1_word_r.frame_start;
  assign src_col_e = fs ? '0 : src_col_r;
  assign src_row_e = fs ? '0 : src_row_r;
  assign out_col_e = fs ? '0 : out_col_r;
  assign out_row_e = fs ? '0 : out_row_r;
  assign col_ss_e  = fs ? '0 : col_ss_r;
  assign col_ts_e  = fs ? '0 : col_ts_r;
  assign row_ss_e  = fs ? '0 : row_ss_r;
  assign row_ts_e  = fs ? '0 : row_ts_r;

  // nearest-neighbour test on the running sums
  assign row_hit = (out_row_e < tgt_h_r) && (row_ts_e >= row_ss_e) &&
                   ((SB+1)'(row_ts_e) < ((SB+1)'(row_ss_e) + (SB+1)'(tgt_h_r)));
  assign col_hit = (out_col_e < tgt_w_r) && (col_ts_e >= col_ss_e) &&
                   ((SB+1)'(col_ts_e) < ((SB+1)'(col_ss_e) + (SB+1)'(tgt_w_r)));
  assign hit     = row_hit && col_hit;

  assign col_last = ((CB+1)'(src_col_e) + (CB+1)'(1)) >= (CB+1)'(src_w_r);
  assign row_last = ((CB+1)'(src_row_e) + (CB+1)'(1)) >= (CB+1)'(src_h_r);
  assign last_col = ((CB+1)'(out_col_e) + (CB+1)'(1)) == (CB+1)'(tgt_w_r);
  assign last_row = ((CB+1)'(out_row_e) + (CB+1)'(1)) == (CB+1)'(tgt_h_r);

  // handshake: hold the input word only when a selected word meets a stalled result
  assign process  = s1_valid_r && (!hit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !process;
  assign load     = in_valid && !in_stall;

  dsg_luma u_luma (
    .pixel (s1_word_r.pixel),
    .gray  (gray)
  );

  // next positions and sums
  always_comb begin
    out_col_nxt = out_col_e;
    col_ts_nxt  = col_ts_e;
    src_col_nxt = src_col_e;
    col_ss_nxt  = col_ss_e;
    src_row_nxt = src_row_e;
    out_row_nxt = out_row_e;
    row_ss_nxt  = row_ss_e;
    row_ts_nxt  = row_ts_e;
    if (hit) begin
      out_col_nxt = out_col_e + CB'(1);
      col_ts_nxt  = col_ts_e + SB'(src_w_r);
    end
    if (!col_last) begin
      src_col_nxt = src_col_e + CB'(1);
      col_ss_nxt  = col_ss_e + SB'(tgt_w_r);
    end else begin
      src_col_nxt = '0;
      out_col_nxt = '0;
      col_ss_nxt  = '0;
      col_ts_nxt  = '0;
      if (row_last) begin
        src_row_nxt = '0;
        out_row_nxt = '0;
        row_ss_nxt  = '0;
        row_ts_nxt  = '0;
      end else begin
        if (row_hit) begin
          out_row_nxt = out_row_e + CB'(1);
          row_ts_nxt  = row_ts_e + SB'(src_h_r);
        end
        src_row_nxt = src_row_e + CB'(1);
        row_ss_nxt  = row_ss_e + SB'(tgt_h_r);
      end
    end
  end

  // result word and valid flags
  always_comb begin
    out_word_nxt.gray      = gray;
    out_word_nxt.row_end   = last_col;
    out_word_nxt.frame_end = last_col && last_row;
    s1_valid_nxt  = load ? 1'b1 : (process ? 1'b0 : s1_valid_r);
    out_valid_nxt = (process && hit) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // advance position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      col_ss_r  <= '0;
      col_ts_r  <= '0;
      row_ss_r  <= '0;
      row_ts_r  <= '0;
    end else if (process) begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      col_ss_r  <= col_ss_nxt;
      col_ts_r  <= col_ts_nxt;
      row_ss_r  <= row_ss_nxt;
      row_ts_r  <= row_ts_nxt;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture words
  always_ff @(posedge clk) begin
    if (load) begin
      s1_word_r <= in_word;
    end
    if (process && hit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dsg_checker.sv -----
`default_nettype none

module dsg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dsg_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a frame ends only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_word.frame_end || out_word.row_end))
    else $error("frame_end without row_end");

  // input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a fresh result follows a word taken into the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input word");

endmodule

bind downsample_rgb565_gray dsg_checker u_dsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ----- tb/downsample_rgb565_gray_tb.sv -----
module downsample_rgb565_gray_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1500;
  localparam int MAX_PRINTS  = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dsg_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dsg_pkg::out_word_t out_word;
  logic               cfg_we = 1'b0;
  logic [dsg_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  downsample_rgb565_gray DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the size registers and the scan position
  logic [11:0] scan_src_w = 12'(dsg_pkg::SRC_W_RST);
  logic [11:0] scan_src_h = 12'(dsg_pkg::SRC_H_RST);
  logic [11:0] scan_dst_w = 12'(dsg_pkg::TGT_W_RST);
  logic [11:0] scan_dst_h = 12'(dsg_pkg::TGT_H_RST);
  logic [11:0] src_col = '0, src_row = '0, dst_col = '0, dst_row = '0;
  logic [23:0] col_src_acc = '0, col_dst_acc = '0, row_src_acc = '0, row_dst_acc = '0;

  dsg_pkg::in_word_t  pixel_q[$];
  dsg_pkg::out_word_t gray_due_q[$];
  dsg_pkg::out_word_t due;
  int mismatches = 0;
  int items_sent = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Expand each channel to 8 bits, then weight and sum
  function automatic logic [7:0] luma8(input logic [15:0] p);
    int r, g, b;
    r = int'(p[15:11]) * 255 / 31;
    g = int'(p[10:5]) * 255 / 63;
    b = int'(p[4:0]) * 255 / 31;
    return 8'((77 * r + 150 * g + 29 * b) >> 8);
  endfunction

  function automatic bit pos_hit(input logic [23:0] scaled, input logic [23:0] aim,
                                 input logic [11:0] step, input logic [11:0] pos,
                                 input logic [11:0] lim);
    return (pos < lim) && (aim >= scaled) && (25'(aim) < 25'(scaled) + 25'(step));
  endfunction

  task automatic clear_cols();
    src_col = '0;
    dst_col = '0;
    col_src_acc = '0;
    col_dst_acc = '0;
  endtask

  task automatic clear_rows();
    src_row = '0;
    dst_row = '0;
    row_src_acc = '0;
    row_dst_acc = '0;
  endtask

  // Advance the scan by one source word and queue the luma it selects, if any
  task automatic scan_pixel(input dsg_pkg::in_word_t w);
    bit row_hit, col_hit, last_col, last_row;
    dsg_pkg::out_word_t res;
    if (w.frame_start) begin
      clear_cols();
      clear_rows();
    end
    row_hit = pos_hit(row_src_acc, row_dst_acc, scan_dst_h, dst_row, scan_dst_h);
    col_hit = pos_hit(col_src_acc, col_dst_acc, scan_dst_w, dst_col, scan_dst_w);
    if (row_hit && col_hit) begin
      last_col = (13'(dst_col) + 13'd1 == 13'(scan_dst_w));
      last_row = (13'(dst_row) + 13'd1 == 13'(scan_dst_h));
      res.gray      = luma8(w.pixel);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      gray_due_q.push_back(res);
      dst_col = dst_col + 12'd1;
      col_dst_acc = col_dst_acc + 24'(scan_src_w);
    end
    if (13'(src_col) + 13'd1 < 13'(scan_src_w)) begin
      src_col = src_col + 12'd1;
      col_src_acc = col_src_acc + 24'(scan_dst_w);
    end else begin
      clear_cols();
      // A zero height behaves as one: every row is the last
      if (13'(src_row) + 13'd1 >= 13'(scan_src_h)) begin
        clear_rows();
      end else begin
        if (row_hit) begin
          dst_row = dst_row + 12'd1;
          row_dst_acc = row_dst_acc + 24'(scan_src_h);
        end
        src_row = src_row + 12'd1;
        row_src_acc = row_src_acc + 24'(scan_dst_h);
      end
    end
  endtask

  // Sender: take accepted words into the scan, then load the next in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        scan_pixel(in_word);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_word <= pixel_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between free running, light and heavy stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gray_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word gray=%0d row_end=%0b frame_end=%0b",
                                  out_word.gray, out_word.row_end, out_word.frame_end));
      end else begin
        due = gray_due_q.pop_front();
        if (out_word.gray !== due.gray)
          report_mismatch($sformatf("gray %0d, expected %0d", out_word.gray, due.gray));
        if (out_word.row_end !== due.row_end)
          report_mismatch($sformatf("row_end %0b, expected %0b",
                                    out_word.row_end, due.row_end));
        if (out_word.frame_end !== due.frame_end)
          report_mismatch($sformatf("frame_end %0b, expected %0b",
                                    out_word.frame_end, due.frame_end));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_item(input logic [15:0] pixel, input bit fs);
    dsg_pkg::in_word_t w;
    w.pixel = pixel;
    w.frame_start = fs;
    pixel_q.push_back(w);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Queue n words cut into frames of frame_len; noise adds or drops frame starts
  task automatic queue_run(input longint frame_len, input int n, input bit lead,
                           input bit noisy);
    bit fs;
    for (int i = 0; i < n; i++) begin
      fs = (frame_len != 0) && (i % frame_len == 0) && (i != 0 || lead);
      if (noisy && $urandom_range(0, 24) == 0)
        fs = !fs;
      queue_item(rand_pixel(), fs);
    end
  endtask

  // Wait until every word is taken and answered, then let the pipeline drain
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || gray_due_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_sizes(input logic [11:0] sw, input logic [11:0] sh,
                            input logic [11:0] tw, input logic [11:0] th);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= dsg_pkg::CFG_SRC_W;
    cfg_data <= sw;
    scan_src_w = sw;
    @(posedge clk);
    cfg_index <= dsg_pkg::CFG_SRC_H;
    cfg_data <= sh;
    scan_src_h = sh;
    @(posedge clk);
    cfg_index <= dsg_pkg::CFG_TGT_W;
    cfg_data <= tw;
    scan_dst_w = tw;
    @(posedge clk);
    cfg_index <= dsg_pkg::CFG_TGT_H;
    cfg_data <= th;
    scan_dst_h = th;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int kind, sw, sh, tw, th, frames, n, phase;
    longint frame_len;
    bit lead, noisy;
    logic [15:0] row_pix[15];

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sizes: only every fifth column of the first row is picked
    for (int i = 0; i < 10; i++)
      queue_item((i % 2 == 0) ? 16'hFFFF : 16'h0000, i == 0);
    settle();

    // One-to-one 4x2: channel extremes, a full frame, then a start mid-frame
    load_sizes(12'd4, 12'd2, 12'd4, 12'd2);
    row_pix = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h0841, 16'hF81F,
                16'h7BEF, 16'h8410, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFE0, 16'h07FF,
                16'h0020};
    for (int i = 0; i < 15; i++)
      queue_item(row_pix[i], i == 0 || i == 8 || i == 11);
    settle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = (phase < 3) ? phase + 6 : $urandom_range(0, 9);
      frames = $urandom_range(1, 3);
      lead = 1'b1;
      noisy = 1'b0;
      case (kind)
        6: begin
          // Largest and smallest sizes, left mid-frame for the next phase
          sw = (phase == 0 || $urandom_range(0, 1)) ? 4095 : 1;
          sh = (phase == 0 || $urandom_range(0, 1)) ? 4095 : 1;
          tw = (phase == 0 || $urandom_range(0, 1)) ? 4095 : 1;
          th = (phase == 0 || $urandom_range(0, 1)) ? 4095 : 1;
        end
        7: begin
          // Upscaling: target at least as large as source
          sw = $urandom_range(1, 8);
          sh = $urandom_range(1, 6);
          tw = $urandom_range(sw, 16);
          th = $urandom_range(sh, 10);
        end
        8: begin
          // One size register zero
          sw = $urandom_range(1, 8);
          sh = $urandom_range(1, 4);
          tw = $urandom_range(1, sw);
          th = $urandom_range(1, sh);
          case ($urandom_range(0, 3))
            0: sw = 0;
            1: sh = 0;
            2: tw = 0;
            default: th = 0;
          endcase
        end
        default: begin
          sw = $urandom_range(1, 16);
          sh = $urandom_range(1, 8);
          tw = $urandom_range(1, sw);
          th = $urandom_range(1, sh);
          lead = ($urandom_range(0, 3) != 0);
          noisy = (kind == 5);
        end
      endcase
      if (kind == 9) begin
        // Keep the sizes and carry on from wherever the scan stands
        queue_run(0, $urandom_range(20, 60), 1'b0, 1'b1);
      end else begin
        load_sizes(12'(sw), 12'(sh), 12'(tw), 12'(th));
        frame_len = longint'((sw > 0) ? sw : 1) * longint'((sh > 0) ? sh : 1);
        n = (frame_len * frames > 300) ? 300 : int'(frame_len * frames);
        queue_run(frame_len, n, lead, noisy);
      end
      settle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (gray_due_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", gray_due_q.size()));
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
